// ===== sv/gdad_pkg.sv =====
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared types, constants and calendar helpers for the date advance unit.
// ----------------------------------------------------------------------------
package gdad_pkg;

    localparam int YEAR_WIDTH_DEF = 14;
    localparam int ADD_WIDTH_DEF  = 16;

    localparam int LEAP_CYCLE = 400;
    localparam int CENTURY    = 100;
    localparam int LAST_MONTH = 12;
    localparam int LEAP_FEB   = 29;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_INVALID  = 2'd1,
        STS_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_WALK,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic reduce_step;
        logic check;
        logic walk_step;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic reduce_last;
        logic walk_done;
        logic out_free;
    } t_sts;

    // days in month m; 0 for a month code outside 1..12
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = leap ? 5'(LEAP_FEB) : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== sv/gdad_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdad_ctrl
// Sequencer: reduces the year mod 400, checks the date, walks the months.
// ----------------------------------------------------------------------------
module gdad_ctrl
    import gdad_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.reduce_step = 1'b1;
                if (i_sts.reduce_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_WALK;
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== sv/gdad_dp.sv =====
// ----------------------------------------------------------------------------
// gdad_dp
// Date registers, year-mod-400 reducer, month step and output register.
// ----------------------------------------------------------------------------
module gdad_dp
    import gdad_pkg::*;
#(
    parameter int YEAR_WIDTH = YEAR_WIDTH_DEF,
    parameter int ADD_WIDTH  = ADD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [4:0]            i_start_day,
    input  logic [3:0]            i_start_month,
    input  logic [YEAR_WIDTH-1:0] i_start_year,
    input  logic [ADD_WIDTH-1:0]  i_days_to_add,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [4:0]            o_result_day,
    output logic [3:0]            o_result_month,
    output logic [YEAR_WIDTH-1:0] o_result_year,
    output logic [1:0]            o_status
);

    localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = {YEAR_WIDTH{1'b1}};
    // ceil(2^RECIP_SHIFT / 400): year * RECIP >> RECIP_SHIFT is the exact quotient
    // for every YEAR_WIDTH-bit year
    localparam int RECIP_SHIFT = YEAR_WIDTH + 9;
    localparam logic [YEAR_WIDTH:0] RECIP = (YEAR_WIDTH+1)'(
        ((64'd1 << RECIP_SHIFT) + 64'(LEAP_CYCLE - 1)) / 64'(LEAP_CYCLE));
    localparam int QUOT_WIDTH = YEAR_WIDTH - 8;

    logic [4:0]            r_day;
    logic [3:0]            r_month;
    logic [YEAR_WIDTH-1:0] r_year;
    logic [ADD_WIDTH-1:0]  r_left;
    logic [YEAR_WIDTH-1:0] r_rem;
    logic [QUOT_WIDTH-1:0] r_quot;
    logic                  r_red_phase;
    t_status               r_status;

    logic                  r_out_valid;
    logic [4:0]            r_out_day;
    logic [3:0]            r_out_month;
    logic [YEAR_WIDTH-1:0] r_out_year;
    t_status               r_out_status;

    logic [8:0]            rem9;
    logic                  leap;
    logic [4:0]            len;
    logic                  invalid;
    logic [ADD_WIDTH:0]    sum;
    logic                  fits;
    logic [ADD_WIDTH-1:0]  left_after;
    logic [2*YEAR_WIDTH:0] prod;
    logic [YEAR_WIDTH-1:0] quot_scaled;

    assign rem9 = r_rem[8:0];
    // century years are leap only when divisible by 400
    assign leap = (r_year[1:0] == 2'b00) &&
                  !(rem9 == 9'(CENTURY) || rem9 == 9'(2 * CENTURY) ||
                    rem9 == 9'(3 * CENTURY));
    assign len  = month_len(r_month, leap);

    assign invalid = (r_month < 4'd1) || (r_month > 4'(LAST_MONTH)) ||
                     (r_day == 5'd0) || (r_day > len);

    assign sum        = {1'b0, r_left} + (ADD_WIDTH+1)'(r_day);
    assign fits       = sum <= (ADD_WIDTH+1)'(len);
    assign left_after = r_left - ADD_WIDTH'(len) + ADD_WIDTH'(r_day) - ADD_WIDTH'(1);

    assign prod        = (2*YEAR_WIDTH+1)'(r_rem) * (2*YEAR_WIDTH+1)'(RECIP);
    assign quot_scaled = YEAR_WIDTH'(r_quot) * YEAR_WIDTH'(LEAP_CYCLE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day       <= i_start_day;
            r_month     <= i_start_month;
            r_year      <= i_start_year;
            r_left      <= i_days_to_add;
            r_rem       <= i_start_year;
            r_red_phase <= 1'b0;
            r_status    <= STS_OK;
        end else if (i_cmd.reduce_step) begin
            // first step: quotient by 400; second: subtract it back out
            if (!r_red_phase) begin
                r_quot      <= prod[RECIP_SHIFT +: QUOT_WIDTH];
                r_red_phase <= 1'b1;
            end else begin
                r_rem <= r_rem - quot_scaled;
            end
        end else if (i_cmd.check) begin
            if (invalid) begin
                r_status <= STS_INVALID;
                r_left   <= '0;
            end
        end else if (i_cmd.walk_step) begin
            if (fits) begin
                r_day  <= r_day + 5'(r_left);
                r_left <= '0;
            end else if (r_month < 4'(LAST_MONTH)) begin
                r_day   <= 5'd1;
                r_month <= r_month + 4'd1;
                r_left  <= left_after;
            end else if (r_year == YEAR_MAX) begin
                // saturate at the last representable date
                r_day    <= 5'd31;
                r_month  <= 4'(LAST_MONTH);
                r_status <= STS_OVERFLOW;
                r_left   <= '0;
            end else begin
                r_day   <= 5'd1;
                r_month <= 4'd1;
                r_year  <= r_year + YEAR_WIDTH'(1);
                r_left  <= left_after;
                r_rem   <= (rem9 == 9'(LEAP_CYCLE - 1)) ? '0 : r_rem + YEAR_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_day    <= r_day;
            r_out_month  <= r_month;
            r_out_year   <= r_year;
            r_out_status <= r_status;
        end
    end

    assign o_sts.reduce_last = r_red_phase;
    assign o_sts.walk_done   = (r_left == '0);
    assign o_sts.out_free    = !r_out_valid || i_ready;

    assign o_valid        = r_out_valid;
    assign o_result_day   = r_out_day;
    assign o_result_month = r_out_month;
    assign o_result_year  = r_out_year;
    assign o_status       = r_out_status;

endmodule

// ===== sv/gregorian_date_add_days_unit.sv =====
// Advances a Gregorian date (day, month, year) by a count of days, one item at
// a time. After an item is taken the year is reduced mod 400 by a reciprocal
// multiply (quotient first, then subtracted back out), the date is checked, and
// then the month-step loop advances one month per cycle. An invalid start date
// comes back unchanged with status 1; a walk past the last representable year
// saturates to 31/12 of that year with status 2. The result sits in an output
// register, so the next item is taken while it waits.
// ----------------------------------------------------------------------------
// gregorian_date_add_days_unit
// Top level: sequencer plus datapath for the date advance.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_unit
    import gdad_pkg::*;
#(
    parameter int YEAR_WIDTH = YEAR_WIDTH_DEF,
    parameter int ADD_WIDTH  = ADD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [4:0]            i_start_day,
    input  logic [3:0]            i_start_month,
    input  logic [YEAR_WIDTH-1:0] i_start_year,
    input  logic [ADD_WIDTH-1:0]  i_days_to_add,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [4:0]            o_result_day,
    output logic [3:0]            o_result_month,
    output logic [YEAR_WIDTH-1:0] o_result_year,
    output logic [1:0]            o_status
);

    t_cmd cmd;
    t_sts sts;

    gdad_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gdad_dp #(
        .YEAR_WIDTH (YEAR_WIDTH),
        .ADD_WIDTH  (ADD_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_start_day    (i_start_day),
        .i_start_month  (i_start_month),
        .i_start_year   (i_start_year),
        .i_days_to_add  (i_days_to_add),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_day   (o_result_day),
        .o_result_month (o_result_month),
        .o_result_year  (o_result_year),
        .o_status       (o_status)
    );

endmodule

// ===== sv/gdad_chk.sv =====
// ----------------------------------------------------------------------------
// gdad_chk
// Port-level checks for the date advance unit, bound to the top level.
// ----------------------------------------------------------------------------
module gdad_chk
    import gdad_pkg::*;
#(
    parameter int YEAR_WIDTH = YEAR_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [4:0]            o_result_day,
    input logic [3:0]            o_result_month,
    input logic [YEAR_WIDTH-1:0] o_result_year,
    input logic [1:0]            o_status
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_day) &&
        $stable(o_result_month) && $stable(o_result_year) && $stable(o_status))
        else $error("result changed while stalled");

    // one item in flight: busy right after taking an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken again while busy");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != STS_OVERFLOW + 2'd1)
        else $error("unused status code");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STS_OVERFLOW |->
        o_result_day == 5'd31 && o_result_month == 4'(LAST_MONTH) &&
        o_result_year == {YEAR_WIDTH{1'b1}})
        else $error("overflow result not saturated");

    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STS_OK |->
        o_result_day != 5'd0 && o_result_month != 4'd0 &&
        o_result_month <= 4'(LAST_MONTH))
        else $error("ok result is not a calendar date");

endmodule

bind gregorian_date_add_days_unit gdad_chk #(
    .YEAR_WIDTH (YEAR_WIDTH)
) u_gdad_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_result_day   (o_result_day),
    .o_result_month (o_result_month),
    .o_result_year  (o_result_year),
    .o_status       (o_status)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Random and directed test of the Gregorian date advance unit. Each accepted
// item is run through a behavioural calendar walk; results are compared in
// order, field by field, against that prediction.
// ----------------------------------------------------------------------------

class date_board;

    typedef struct {
        logic [4:0]                          day;
        logic [3:0]                          month;
        logic [gdad_pkg::YEAR_WIDTH_DEF-1:0] year;
        gdad_pkg::t_status                   status;
    } date_t;

    date_t       awaited[$];
    int unsigned errors;
    int unsigned n_items;
    int unsigned n_ok;
    int unsigned n_invalid;
    int unsigned n_overflow;
    int unsigned n_checked;

    function new();
        errors     = 0;
        n_items    = 0;
        n_ok       = 0;
        n_invalid  = 0;
        n_overflow = 0;
        n_checked  = 0;
    endfunction

    static function int unsigned month_days(int unsigned m, int unsigned y);
        bit leap;
        leap = ((y % 4 == 0) && (y % gdad_pkg::CENTURY != 0))
               || (y % gdad_pkg::LEAP_CYCLE == 0);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? gdad_pkg::LEAP_FEB : 28;
            default:               return 0;
        endcase
    endfunction

    // walk the calendar a month at a time, saturating past the last year
    function date_t date_after(int unsigned d, int unsigned m, int unsigned y,
                               int unsigned n);
        date_t       r;
        int unsigned len;
        int unsigned year_top;
        year_top = (1 << gdad_pkg::YEAR_WIDTH_DEF) - 1;
        r.status = gdad_pkg::STS_OK;
        if (m < 1 || m > gdad_pkg::LAST_MONTH || d < 1 || d > month_days(m, y)) begin
            r.status = gdad_pkg::STS_INVALID;
        end else begin
            while (n > 0) begin
                len = month_days(m, y);
                if (d + n <= len) begin
                    d = d + n;
                    n = 0;
                end else begin
                    n = n - (len - d + 1);
                    d = 1;
                    if (m < gdad_pkg::LAST_MONTH) begin
                        m = m + 1;
                    end else if (y >= year_top) begin
                        r.status = gdad_pkg::STS_OVERFLOW;
                        d = 31;
                        m = gdad_pkg::LAST_MONTH;
                        y = year_top;
                        break;
                    end else begin
                        m = 1;
                        y = y + 1;
                    end
                end
            end
        end
        r.day   = d[4:0];
        r.month = m[3:0];
        r.year  = y[gdad_pkg::YEAR_WIDTH_DEF-1:0];
        return r;
    endfunction

    function void note_item(logic [4:0] d, logic [3:0] m,
                            logic [gdad_pkg::YEAR_WIDTH_DEF-1:0] y,
                            logic [gdad_pkg::ADD_WIDTH_DEF-1:0] n);
        date_t e;
        e = date_after(d, m, y, n);
        awaited.push_back(e);
        n_items++;
        case (e.status)
            gdad_pkg::STS_OK:      n_ok++;
            gdad_pkg::STS_INVALID: n_invalid++;
            default:               n_overflow++;
        endcase
    endfunction

    function void check_item(logic [4:0] d, logic [3:0] m,
                             logic [gdad_pkg::YEAR_WIDTH_DEF-1:0] y, logic [1:0] s);
        date_t e;
        if (awaited.size() == 0) begin
            $error("result with no item outstanding: %0d/%0d/%0d status %0d", d, m, y, s);
            errors++;
            return;
        end
        e = awaited.pop_front();
        n_checked++;
        if (d !== e.day) begin
            $error("result_day: expected %0d, got %0d", e.day, d);
            errors++;
        end
        if (m !== e.month) begin
            $error("result_month: expected %0d, got %0d", e.month, m);
            errors++;
        end
        if (y !== e.year) begin
            $error("result_year: expected %0d, got %0d", e.year, y);
            errors++;
        end
        if (s !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, s);
            errors++;
        end
    endfunction

    function int unsigned pending();
        return awaited.size();
    endfunction

endclass

module testbench;
    import gdad_pkg::*;

    localparam int YW         = YEAR_WIDTH_DEF;
    localparam int AW         = ADD_WIDTH_DEF;
    localparam int YEAR_TOP   = (1 << YW) - 1;
    localparam int QUIET_MAX  = 12000;  // several times the slowest item plus stalls
    localparam int N_RANDOM   = 250;

    logic          i_clk          = 1'b0;
    logic          i_rst_n        = 1'b0;
    logic          i_valid        = 1'b0;
    logic [4:0]    i_start_day    = '0;
    logic [3:0]    i_start_month  = '0;
    logic [YW-1:0] i_start_year   = '0;
    logic [AW-1:0] i_days_to_add  = '0;
    logic          i_ready        = 1'b0;
    logic          o_ready;
    logic          o_valid;
    logic [4:0]    o_result_day;
    logic [3:0]    o_result_month;
    logic [YW-1:0] o_result_year;
    logic [1:0]    o_status;

    date_board     ledger;
    logic          calm         = 1'b0;
    int            quiet_cycles = 0;
    int            ready_hold   = 0;

    gregorian_date_add_days_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_start_day    (i_start_day),
        .i_start_month  (i_start_month),
        .i_start_year   (i_start_year),
        .i_days_to_add  (i_days_to_add),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_day   (o_result_day),
        .o_result_month (o_result_month),
        .o_result_year  (o_result_year),
        .o_status       (o_status)
    );

    always #4 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 120);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [YW-1:0] pick_year();
        case ($urandom_range(0, 4))
            0:       return YW'($urandom_range(0, 2500));
            1:       return YW'($urandom_range(0, YEAR_TOP));
            2:       return YW'($urandom_range(YEAR_TOP - 200, YEAR_TOP));
            3:       return YW'($urandom_range(0, YEAR_TOP / CENTURY) * CENTURY);
            default: return YW'($urandom_range(0, YEAR_TOP / LEAP_CYCLE) * LEAP_CYCLE);
        endcase
    endfunction

    // small counts dominate; the full range is kept for a minority of items
    function automatic logic [AW-1:0] pick_span();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 4)   return AW'($urandom_range(0, 40));
        if (r < 9)   return AW'($urandom_range(0, 400));
        if (r < 15)  return AW'($urandom_range(0, 4000));
        if (r == 15) return '1;
        return AW'($urandom_range(0, (1 << AW) - 1));
    endfunction

    task automatic send_item(input logic [4:0] d, input logic [3:0] m,
                             input logic [YW-1:0] y, input logic [AW-1:0] n);
        i_valid       <= 1'b1;
        i_start_day   <= d;
        i_start_month <= m;
        i_start_year  <= y;
        i_days_to_add <= n;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (ledger.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_random();
        int unsigned   kind;
        int unsigned   len;
        logic [4:0]    d;
        logic [3:0]    m;
        logic [YW-1:0] y;
        kind = $urandom_range(0, 9);
        y    = pick_year();
        m    = 4'($urandom_range(1, LAST_MONTH));
        len  = ledger.month_days(m, y);
        if (kind < 7) begin
            case ($urandom_range(0, 5))
                0:       d = 5'd1;
                1:       d = 5'(len);
                2:       d = 5'(len - 1);
                default: d = 5'($urandom_range(1, len));
            endcase
        end else if (kind < 9) begin
            // malformed dates
            case ($urandom_range(0, 3))
                0: begin
                    m = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
                    d = 5'($urandom_range(0, 31));
                end
                1: d = 5'd0;
                2: d = (len == 31) ? 5'd0 : 5'($urandom_range(len + 1, 31));
                default: begin
                    m = 4'd2;
                    d = 5'(LEAP_FEB);
                    y = ($urandom_range(0, 1) == 0)
                        ? YW'($urandom_range(0, YEAR_TOP / 2) * 2 + 1)
                        : YW'(($urandom_range(0, YEAR_TOP / LEAP_CYCLE - 1) * 4
                               + $urandom_range(1, 3)) * CENTURY);
                end
            endcase
        end else begin
            d = 5'($urandom_range(0, 31));
            m = 4'($urandom_range(0, 15));
            y = YW'($urandom_range(0, YEAR_TOP));
        end
        send_item(d, m, y, pick_span());
    endtask

    // receiver side: random back-pressure unless in a calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (calm) begin
            i_ready    <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_ready    <= 1'b0;
            ready_hold <= pick_gap();
        end else begin
            i_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 8);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                ledger.note_item(i_start_day, i_start_month, i_start_year, i_days_to_add);
            if (o_valid && i_ready)
                ledger.check_item(o_result_day, o_result_month, o_result_year, o_status);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_MAX) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        ledger = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero span, year extremes, saturation, leap rules, malformed dates
        send_item(5'd1,  4'd1,  YW'(0),        AW'(0));
        send_item(5'd31, 4'd12, YW'(YEAR_TOP), AW'(0));
        send_item(5'd31, 4'd12, YW'(YEAR_TOP), AW'(1));
        pause_sender(pick_gap());
        send_item(5'd1,  4'd1,  YW'(16300),    '1);
        send_item(5'd29, 4'd2,  YW'(2000),     AW'(1));
        send_item(5'd29, 4'd2,  YW'(1900),     AW'(0));
        send_item(5'd29, 4'd2,  YW'(2100),     AW'(5));
        send_item(5'd29, 4'd2,  YW'(2024),     AW'(365));
        send_item(5'd28, 4'd2,  YW'(2023),     AW'(1));
        pause_sender(pick_gap());
        send_item(5'd0,  4'd5,  YW'(2020),     AW'(10));
        send_item(5'd1,  4'd0,  YW'(2020),     AW'(10));
        send_item(5'd1,  4'd13, YW'(2020),     AW'(10));
        send_item(5'd31, 4'd15, YW'(YEAR_TOP), '1);
        send_item(5'd31, 4'd4,  YW'(2021),     AW'(1));
        send_item(5'd31, 4'd2,  YW'(2000),     AW'(1));
        send_item(5'd31, 4'd1,  YW'(0),        '1);
        send_item(5'd1,  4'd1,  YW'(0),        '1);
        send_item(5'd31, 4'd12, YW'(1999),     AW'(1));
        send_item(5'd29, 4'd2,  YW'(0),        AW'(366));
        send_item(5'd30, 4'd11, YW'(YEAR_TOP), AW'(31));
        send_item(5'd30, 4'd11, YW'(YEAR_TOP), AW'(32));
        send_item(5'd1,  4'd3,  YW'(YEAR_TOP), AW'(305));
        send_item(5'd1,  4'd3,  YW'(YEAR_TOP), AW'(306));
        send_item(5'd15, 4'd6,  YW'(YEAR_TOP), AW'(200));

        // hold the sender until the unit has nothing outstanding
        i_valid <= 1'b0;
        drain();

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == 60)  calm <= 1'b1;
            if (k == 110) calm <= 1'b0;
            if (!(k >= 60 && k < 110))
                pause_sender(pick_gap());
            send_random();
        end
        i_valid <= 1'b0;

        drain();
        repeat (100) @(posedge i_clk);

        $display("%0d items sent, %0d results checked, %0d errors", ledger.n_items,
                 ledger.n_checked, ledger.errors);
        $display("mix: %0d advanced, %0d invalid start dates, %0d saturated at the last year",
                 ledger.n_ok, ledger.n_invalid, ledger.n_overflow);
        if (ledger.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
